// ===== design/itss_pkg.sv =====
// Shared types and codes for the integer table search, sort and delete engine.
package itss_pkg;

  // Operation codes
  localparam logic [3:0] FN_CLEAR        = 4'd0;
  localparam logic [3:0] FN_APPEND       = 4'd1;
  localparam logic [3:0] FN_SEARCH       = 4'd2;
  localparam logic [3:0] FN_LIST         = 4'd3;
  localparam logic [3:0] FN_RANGE        = 4'd4;
  localparam logic [3:0] FN_SORT_UP      = 4'd5;
  localparam logic [3:0] FN_SORT_DOWN    = 4'd6;
  localparam logic [3:0] FN_REMOVE_FIRST = 4'd7;
  localparam logic [3:0] FN_REMOVE_ALL   = 4'd8;

  // Result status codes
  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_NOMATCH = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  // Most results returned for one request
  localparam logic [6:0] RES_CAP = 7'd64;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] operand_value;
    logic signed [31:0] range_upper;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
    logic               last;
  } rsp_t;

endpackage

// ===== design/itss_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface itss_req_if import itss_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface itss_rsp_if import itss_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/itss_ram.sv =====
// Generic simple dual-port RAM with registered read.
module itss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/integer_table_search_sort_delete.sv =====
// Top level of the integer table search, sort and delete engine.
//
// Holds a compact table of up to DEPTH signed 32-bit values in a RAM plus a
// live-entry count. A request (func, operand_value, range_upper) arrives on
// req_i; results (status, entry_index, entry_value, last) leave on rsp_o,
// the final result of every request carrying last = 1. Unused func codes
// are taken and give no result.
// One sequencer drives a single RAM read port and the compare logic; each
// table access is an address step followed by a use of the registered data.
// Search, list, range and remove-all make one pass over the table;
// remove-first scans up to the hit, then shifts the later entries down;
// sorts run insertion sort over the table and then list it in order.
// req_i.ready is high only while no request is in progress.
// Results pass through a one-deep hold stage and an output register, so
// a stalled receiver simply freezes the sequencer; nothing is dropped.
// Reset clears the entry count and all control state; the RAM needs no
// clearing since only entries below the count are ever read.
module integer_table_search_sort_delete import itss_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itss_req_if.sink   req_i,
  itss_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_USE = 4'd2;
  localparam logic [3:0] S_SHIFT_RD = 4'd3;
  localparam logic [3:0] S_SHIFT_WR = 4'd4;
  localparam logic [3:0] S_SORT_I   = 4'd5;
  localparam logic [3:0] S_SORT_V   = 4'd6;
  localparam logic [3:0] S_SORT_RD  = 4'd7;
  localparam logic [3:0] S_SORT_CMP = 4'd8;
  localparam logic [3:0] S_FLUSH    = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [3:0]         op_q;
  logic signed [31:0] key_q, hi_q;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      i_q, i_d;
  logic [CW-1:0]      j_q, j_d;
  logic signed [31:0] v_q, v_d;
  logic [6:0]         emit_cnt_q;

  logic               pend_v_q;
  rsp_t               pend_q;
  logic               out_v_q;
  rsp_t               out_q;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [31:0]        ram_wdata, ram_rdata;
  logic signed [31:0] rd;

  logic               accept, can_push, stall, emit_fire, flush_go;
  logic               emit_req, emit_ok, match, in_rng, shift_up;
  logic [2:0]         emit_st;
  logic [5:0]         emit_idx;
  logic [31:0]        emit_val;

  assign rd        = $signed(ram_rdata);
  assign accept    = req_i.valid && req_i.ready;
  assign can_push  = !out_v_q || rsp_o.ready;
  assign emit_ok   = emit_req && (emit_cnt_q < RES_CAP);
  assign stall     = emit_ok && pend_v_q && !can_push;
  assign emit_fire = emit_ok && !stall;
  assign flush_go  = (state_q == S_FLUSH) && can_push;
  assign match     = (rd == key_q);
  assign in_rng    = !(rd < key_q) && !(hi_q < rd);
  assign shift_up  = (op_q == FN_SORT_DOWN) ? (rd < v_q) : (v_q < rd);

  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = out_v_q;
  assign rsp_o.payload = out_q;

  itss_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    i_d       = i_q;
    j_d       = j_q;
    v_d       = v_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    emit_req  = 1'b0;
    emit_st   = ST_DONE;
    emit_idx  = '0;
    emit_val  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (req_i.payload.func == FN_CLEAR) begin
            count_d  = '0;
            emit_req = 1'b1;
            state_d  = S_FLUSH;
          end else if (req_i.payload.func == FN_APPEND) begin
            emit_req = 1'b1;
            if (count_q == CNT_FULL) begin
              emit_st = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = AW'(count_q);
              ram_wdata = req_i.payload.operand_value;
              count_d   = count_q + CNT_ONE;
            end
            state_d = S_FLUSH;
          end else if (req_i.payload.func > FN_REMOVE_ALL) begin
            state_d = S_IDLE;
          end else if (count_q == '0) begin
            emit_req = 1'b1;
            emit_st  = ST_EMPTY;
            state_d  = S_FLUSH;
          end else if (req_i.payload.func == FN_SORT_UP ||
                       req_i.payload.func == FN_SORT_DOWN) begin
            i_d     = CNT_ONE;
            state_d = S_SORT_I;
          end else begin
            idx_d   = '0;
            i_d     = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          unique case (op_q)
            FN_SEARCH, FN_RANGE, FN_REMOVE_FIRST: begin
              emit_req = (emit_cnt_q == '0);
              emit_st  = ST_NOMATCH;
            end
            FN_REMOVE_ALL: begin
              count_d  = i_q;
              emit_req = 1'b1;
              emit_st  = (i_q == count_q) ? ST_NOMATCH : ST_DONE;
            end
            default: emit_req = 1'b0;
          endcase
          state_d = S_FLUSH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_q);
          state_d   = S_SCAN_USE;
        end
      end
      S_SCAN_USE: begin
        emit_st  = ST_DATA;
        emit_idx = 6'(idx_q);
        emit_val = ram_rdata;
        unique case (op_q)
          FN_SEARCH: emit_req = match;
          FN_RANGE:  emit_req = in_rng;
          FN_LIST, FN_SORT_UP, FN_SORT_DOWN: emit_req = 1'b1;
          FN_REMOVE_ALL: begin
            if (!match) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(i_q);
              ram_wdata = ram_rdata;
              i_d       = i_q + CNT_ONE;
            end
          end
          default: emit_req = 1'b0;
        endcase
        if (op_q == FN_REMOVE_FIRST && match) begin
          // shift later entries down over the hit
          i_d     = idx_q;
          state_d = S_SHIFT_RD;
        end else if (!stall) begin
          idx_d   = idx_q + CNT_ONE;
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if ((idx_q + CNT_ONE) >= count_q) begin
          count_d  = count_q - CNT_ONE;
          emit_req = 1'b1;
          emit_idx = 6'(i_q);
          emit_val = key_q;
          state_d  = S_FLUSH;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_q + CNT_ONE);
          state_d   = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_q);
        ram_wdata = ram_rdata;
        idx_d     = idx_q + CNT_ONE;
        state_d   = S_SHIFT_RD;
      end
      // insertion sort: pick entry i, slide larger (or smaller) ones up
      S_SORT_I: begin
        if (i_q >= count_q) begin
          idx_d   = '0;
          state_d = S_SCAN_RD;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(i_q);
          state_d   = S_SORT_V;
        end
      end
      S_SORT_V: begin
        v_d     = rd;
        j_d     = i_q;
        state_d = S_SORT_RD;
      end
      S_SORT_RD: begin
        if (j_q == '0) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = v_q;
          i_d       = i_q + CNT_ONE;
          state_d   = S_SORT_I;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(j_q - CNT_ONE);
          state_d   = S_SORT_CMP;
        end
      end
      S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(j_q);
        if (shift_up) begin
          ram_wdata = ram_rdata;
          j_d       = j_q - CNT_ONE;
          state_d   = S_SORT_RD;
        end else begin
          ram_wdata = v_q;
          i_d       = i_q + CNT_ONE;
          state_d   = S_SORT_I;
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // a result that cannot be taken yet holds the sequencer where it is
    if (stall) begin
      state_d = state_q;
      count_d = count_q;
      idx_d   = idx_q;
      i_d     = i_q;
      j_d     = j_q;
      v_d     = v_q;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      emit_cnt_q <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (flush_go) begin
        emit_cnt_q <= '0;
      end else if (emit_fire) begin
        emit_cnt_q <= emit_cnt_q + 7'd1;
      end
      if (emit_fire) begin
        pend_v_q <= 1'b1;
      end else if (flush_go) begin
        pend_v_q <= 1'b0;
      end
      if ((emit_fire && pend_v_q) || flush_go) begin
        out_v_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    i_q   <= i_d;
    j_q   <= j_d;
    v_q   <= v_d;
    if (accept) begin
      op_q  <= req_i.payload.func;
      key_q <= req_i.payload.operand_value;
      hi_q  <= req_i.payload.range_upper;
    end
    if (emit_fire) begin
      pend_q.status      <= emit_st;
      pend_q.entry_index <= emit_idx;
      pend_q.entry_value <= emit_val;
      pend_q.last        <= 1'b0;
    end
    // held result moves out when a newer one arrives, or as final at flush
    if (emit_fire && pend_v_q) begin
      out_q <= pend_q;
    end else if (flush_go) begin
      out_q <= '{status: pend_q.status, entry_index: pend_q.entry_index,
                 entry_value: pend_q.entry_value, last: 1'b1};
    end
  end

endmodule

// ===== design/itss_checker.sv =====
// Port-level checker for the table engine, bound to the top level.
module itss_checker import itss_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_status_i,
  input logic       rsp_last_i
);

  // a result waiting on the receiver stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // a non-final result means the request is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> !req_ready_i)
    else $error("engine idle before final result");

  // every status other than a data item closes the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_DATA) |-> rsp_last_i)
    else $error("status result not marked final");

endmodule

bind integer_table_search_sort_delete itss_checker u_itss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.payload.status),
  .rsp_last_i   (rsp_o.payload.last)
);
